/* rtl/fwpi_pkg.sv */
// Shared constants, types and saturation helpers for the four-wheel PI speed controller.
`timescale 1ns / 1ps

package fwpi_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int WHL_W      = $clog2(NUM_WHEELS);

    localparam int CNT_W  = 32;
    localparam int TGT_W  = 24;
    localparam int EFF_W  = 16;
    localparam int GAIN_W = 24;
    localparam int ZERO_W = 16;
    localparam int DB_W   = 15;
    localparam int SUM_W  = 32;

    // signed 32 x unsigned 24 product, and the sum of two of them
    localparam int PROD_W = SUM_W + GAIN_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int FRAC_W = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam int S_DATA_W = NUM_WHEELS * (CNT_W + TGT_W);
    localparam int M_DATA_W = NUM_WHEELS * EFF_W;

    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_SCALE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PWM_GAIN    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_PWM    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_KP          = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_KI          = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_MASK    = 3'd6;

    localparam logic [NUM_WHEELS-1:0] DIR_MASK_RST = 4'd14;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_DIFF  = 10'b00_0000_0010,
        ST_SPEED = 10'b00_0000_0100,
        ST_ERR   = 10'b00_0000_1000,
        ST_SCALE = 10'b00_0001_0000,
        ST_MAP   = 10'b00_0010_0000,
        ST_KP    = 10'b00_0100_0000,
        ST_KI    = 10'b00_1000_0000,
        ST_ACC   = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        state_t             step;
        logic [WHL_W-1:0]   wheel;
        logic               load;
    } ctl_t;

    typedef struct packed {
        logic [GAIN_W-1:0]         speed_scale;
        logic [GAIN_W-1:0]         pwm_gain;
        logic signed [ZERO_W-1:0]  idle_pwm;
        logic [DB_W-1:0]           deadband;
        logic [GAIN_W-1:0]         kp;
        logic [GAIN_W-1:0]         ki;
        logic [NUM_WHEELS-1:0]     dir_mask;
    } cfg_t;

    // clamp to 32-bit signed range
    function automatic logic signed [SUM_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic hi_zero;
        logic hi_one;
        hi_zero = ~|v[ACC_W-1:SUM_W-1];
        hi_one  = &v[ACC_W-1:SUM_W-1];
        if (hi_zero || hi_one) begin
            return v[SUM_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SUM_W-1){1'b1}}};
        end
    endfunction

    // clamp the integer part of the accumulator to 16-bit signed range
    function automatic logic signed [EFF_W-1:0] sat16(input logic signed [ACC_W-SUM_W-1:0] v);
        logic hi_zero;
        logic hi_one;
        hi_zero = ~|v[ACC_W-SUM_W-1:EFF_W-1];
        hi_one  = &v[ACC_W-SUM_W-1:EFF_W-1];
        if (hi_zero || hi_one) begin
            return v[EFF_W-1:0];
        end else if (v[ACC_W-SUM_W-1]) begin
            return {1'b1, {(EFF_W-1){1'b0}}};
        end else begin
            return {1'b0, {(EFF_W-1){1'b1}}};
        end
    endfunction

endpackage

/* rtl/fwpi_mul.sv */
// Shared registered multiplier: signed 32-bit operand times unsigned 24-bit gain.
`timescale 1ns / 1ps

module fwpi_mul (
    input  logic                                 aclk,
    input  logic signed [fwpi_pkg::SUM_W-1:0]    op_a,
    input  logic [fwpi_pkg::GAIN_W-1:0]          op_b,
    output logic signed [fwpi_pkg::PROD_W-1:0]   prod
);

    logic signed [fwpi_pkg::GAIN_W:0]   b_s;
    logic signed [fwpi_pkg::PROD_W-1:0] prod_reg;

    assign b_s = $signed({1'b0, op_b});

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * b_s;
    end

    assign prod = prod_reg;

endmodule

/* rtl/fwpi_seq.sv */
// Sequencer: steps each wheel through the shared multiplier and owns the handshakes.
`timescale 1ns / 1ps

module fwpi_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic             out_load,
    output fwpi_pkg::ctl_t   ctl
);

    fwpi_pkg::state_t                state_reg, state_next;
    logic [fwpi_pkg::WHL_W-1:0]      wheel_reg, wheel_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            last_wheel;

    assign last_wheel = (wheel_reg == fwpi_pkg::WHL_W'(fwpi_pkg::NUM_WHEELS - 1));
    assign s_tready   = (state_reg == fwpi_pkg::ST_IDLE);
    assign out_load   = (state_reg == fwpi_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        wheel_next = wheel_reg;
        unique case (state_reg)
            fwpi_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = fwpi_pkg::ST_DIFF;
                    wheel_next = '0;
                end
            end
            fwpi_pkg::ST_DIFF:  state_next = fwpi_pkg::ST_SPEED;
            fwpi_pkg::ST_SPEED: state_next = fwpi_pkg::ST_ERR;
            fwpi_pkg::ST_ERR:   state_next = fwpi_pkg::ST_SCALE;
            fwpi_pkg::ST_SCALE: state_next = fwpi_pkg::ST_MAP;
            fwpi_pkg::ST_MAP:   state_next = fwpi_pkg::ST_KP;
            fwpi_pkg::ST_KP:    state_next = fwpi_pkg::ST_KI;
            fwpi_pkg::ST_KI:    state_next = fwpi_pkg::ST_ACC;
            fwpi_pkg::ST_ACC: begin
                if (last_wheel) begin
                    state_next = fwpi_pkg::ST_DONE;
                end else begin
                    state_next = fwpi_pkg::ST_DIFF;
                    wheel_next = wheel_reg + 1'b1;
                end
            end
            fwpi_pkg::ST_DONE: begin
                // hold until the output register is free
                if (out_load) begin
                    state_next = fwpi_pkg::ST_IDLE;
                end
            end
            default: state_next = fwpi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fwpi_pkg::ST_IDLE;
            wheel_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wheel_reg    <= wheel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign ctl.step  = state_reg;
    assign ctl.wheel = wheel_reg;
    assign ctl.load  = s_tvalid && s_tready;

endmodule

/* rtl/fwpi_dp.sv */
// Datapath: per-wheel state, operand selection for the shared multiplier, saturation steps.
`timescale 1ns / 1ps

module fwpi_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fwpi_pkg::ctl_t                      ctl,
    input  fwpi_pkg::cfg_t                      cfg,
    input  logic [fwpi_pkg::S_DATA_W-1:0]       in_data,
    input  logic                                in_clear,
    output logic [fwpi_pkg::M_DATA_W-1:0]       efforts
);

    localparam int NW    = fwpi_pkg::NUM_WHEELS;
    localparam int CNT_W = fwpi_pkg::CNT_W;
    localparam int TGT_W = fwpi_pkg::TGT_W;
    localparam int SUM_W = fwpi_pkg::SUM_W;
    localparam int EFF_W = fwpi_pkg::EFF_W;
    localparam int PW    = fwpi_pkg::PROD_W;
    localparam int AW    = fwpi_pkg::ACC_W;
    localparam int FW    = fwpi_pkg::FRAC_W;
    localparam int ZW    = fwpi_pkg::ZERO_W;
    localparam int ZD_W  = ZW + 2;
    localparam int BASE_W = ZD_W + FW;
    localparam int SC_W  = PW - FW;
    localparam int MAP_W = SC_W + 1;

    // captured item
    logic [CNT_W-1:0]        cnt_reg [NW];
    logic signed [TGT_W-1:0] tgt_reg [NW];
    logic                    clr_reg;

    // per-wheel state
    logic [CNT_W-1:0]        last_reg [NW];
    logic signed [SUM_W-1:0] sum_reg  [NW];
    logic signed [EFF_W-1:0] eff_reg  [NW];

    // working registers
    logic signed [SUM_W-1:0] diff_reg, diff_next;
    logic signed [SUM_W-1:0] err_reg, err_next;
    logic signed [SUM_W-1:0] mapped_reg, mapped_next;
    logic signed [PW-1:0]    acc_reg;

    logic [CNT_W-1:0]            cnt_w, last_w;
    logic signed [TGT_W-1:0]     tgt_w;
    logic signed [SUM_W-1:0]     sum_w, sum_base, sum_next;
    logic                        flip;
    logic signed [SUM_W-1:0]     speed;
    logic signed [SUM_W:0]       err_diff, sum_add;
    logic signed [SC_W-1:0]      scaled;
    logic signed [ZD_W-1:0]      zd;
    logic signed [BASE_W-1:0]    base;
    logic signed [MAP_W-1:0]     map_sum;
    logic signed [AW-1:0]        acc_sum;
    logic signed [EFF_W-1:0]     eff_next;

    logic signed [SUM_W-1:0]             mul_a;
    logic [fwpi_pkg::GAIN_W-1:0]         mul_b;
    logic signed [PW-1:0]                prod;

    fwpi_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    always_comb begin
        cnt_w  = cnt_reg[ctl.wheel];
        last_w = last_reg[ctl.wheel];
        tgt_w  = tgt_reg[ctl.wheel];
        sum_w  = sum_reg[ctl.wheel];
        flip   = cfg.dir_mask[ctl.wheel];

        diff_next = $signed(cnt_w - last_w);

        speed    = fwpi_pkg::sat32(AW'(prod));
        err_diff = (SUM_W+1)'(tgt_w) - (SUM_W+1)'(speed);
        err_next = fwpi_pkg::sat32(AW'(err_diff));

        sum_base = clr_reg ? '0 : sum_w;
        sum_add  = (SUM_W+1)'(sum_base) + (SUM_W+1)'(err_reg);
        sum_next = fwpi_pkg::sat32(AW'(sum_add));

        // floor of the gain product in PWM units
        scaled = prod[PW-1:FW];
        if (flip) begin
            zd = ZD_W'($signed(cfg.idle_pwm)) - ZD_W'($signed({1'b0, cfg.deadband}));
        end else begin
            zd = ZD_W'($signed(cfg.idle_pwm)) + ZD_W'($signed({1'b0, cfg.deadband}));
        end
        base = $signed({zd, {FW{1'b0}}});
        if (flip) begin
            map_sum = MAP_W'(base) - MAP_W'(scaled);
            acc_sum = AW'(acc_reg) - AW'(prod);
        end else begin
            map_sum = MAP_W'(base) + MAP_W'(scaled);
            acc_sum = AW'(acc_reg) + AW'(prod);
        end
        mapped_next = fwpi_pkg::sat32(AW'(map_sum));

        // a zero target parks the motor
        if (tgt_w == '0) begin
            eff_next = $signed(cfg.idle_pwm);
        end else begin
            eff_next = fwpi_pkg::sat16(acc_sum[AW-1:SUM_W]);
        end

        unique case (ctl.step)
            fwpi_pkg::ST_SPEED: begin
                mul_a = diff_reg;
                mul_b = cfg.speed_scale;
            end
            fwpi_pkg::ST_SCALE: begin
                mul_a = err_reg;
                mul_b = cfg.pwm_gain;
            end
            fwpi_pkg::ST_KP: begin
                mul_a = mapped_reg;
                mul_b = cfg.kp;
            end
            default: begin
                mul_a = sum_w;
                mul_b = cfg.ki;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            for (int i = 0; i < NW; i++) begin
                cnt_reg[i] <= in_data[i*CNT_W +: CNT_W];
                tgt_reg[i] <= $signed(in_data[NW*CNT_W + i*TGT_W +: TGT_W]);
            end
            clr_reg <= in_clear;
        end
        if (ctl.step == fwpi_pkg::ST_DIFF) begin
            diff_reg <= diff_next;
        end
        if (ctl.step == fwpi_pkg::ST_ERR) begin
            err_reg <= err_next;
        end
        if (ctl.step == fwpi_pkg::ST_MAP) begin
            mapped_reg <= mapped_next;
        end
        if (ctl.step == fwpi_pkg::ST_KI) begin
            acc_reg <= prod;
        end
        if (ctl.step == fwpi_pkg::ST_ACC) begin
            eff_reg[ctl.wheel] <= eff_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NW; i++) begin
                last_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end else begin
            if (ctl.step == fwpi_pkg::ST_DIFF) begin
                last_reg[ctl.wheel] <= cnt_w;
            end
            if (ctl.step == fwpi_pkg::ST_SCALE) begin
                sum_reg[ctl.wheel] <= sum_next;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            efforts[i*EFF_W +: EFF_W] = eff_reg[i];
        end
    end

endmodule

/* rtl/four_wheel_pi_speed_control.sv */
// Top level of the four-wheel encoder velocity PI controller.
`timescale 1ns / 1ps

// Usage:
// One transfer on the s_ channel is one control tick: four wrapping encoder
// counts, four signed Q8.16 target speeds, and a clear flag on s_tuser that
// zeroes every error sum before the tick is applied. One transfer on the m_
// channel returns the four saturated 16-bit PWM efforts for that tick.
// Gains and offsets are set through the write port (cfg_wr_en, cfg_addr,
// cfg_wdata) while the block is idle; unknown addresses are ignored.
// Sequence: all four wheels go through one shared registered multiplier
// in turn, each through difference, speed product, error, gain product,
// mapping, kp product, ki product and accumulate; a new tick is taken
// only after the last wheel, once the sequencer is back in idle.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register: the next tick may be accepted while
// it waits, and that tick then holds in its last step until m_tready frees it.
// Reset (aresetn low, synchronous) clears the stored counts, the error sums,
// the registers (direction mask to 14) and drops m_tvalid.

module four_wheel_pi_speed_control (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // count_fr, count_fl, count_bl, count_br, ref_fr, ref_fl, ref_bl, ref_br
    input  logic [fwpi_pkg::S_DATA_W-1:0]          s_tdata,
    // clear_sums
    input  logic [0:0]                             s_tuser,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // effort_fr, effort_fl, effort_bl, effort_br
    output logic [fwpi_pkg::M_DATA_W-1:0]          m_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_wr_en,
    input  logic [fwpi_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [fwpi_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    fwpi_pkg::cfg_t                       cfg_reg, cfg_next;
    fwpi_pkg::ctl_t                       ctl;
    logic                                 out_load;
    logic [fwpi_pkg::M_DATA_W-1:0]        efforts;
    logic [fwpi_pkg::M_DATA_W-1:0]        m_tdata_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                fwpi_pkg::REG_SPEED_SCALE: cfg_next.speed_scale = cfg_wdata;
                fwpi_pkg::REG_PWM_GAIN:    cfg_next.pwm_gain    = cfg_wdata;
                fwpi_pkg::REG_IDLE_PWM:
                    cfg_next.idle_pwm = $signed(cfg_wdata[fwpi_pkg::ZERO_W-1:0]);
                fwpi_pkg::REG_DEADBAND:    cfg_next.deadband = cfg_wdata[fwpi_pkg::DB_W-1:0];
                fwpi_pkg::REG_KP:          cfg_next.kp = cfg_wdata;
                fwpi_pkg::REG_KI:          cfg_next.ki = cfg_wdata;
                fwpi_pkg::REG_DIR_MASK:
                    cfg_next.dir_mask = cfg_wdata[fwpi_pkg::NUM_WHEELS-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_scale <= '0;
            cfg_reg.pwm_gain    <= '0;
            cfg_reg.idle_pwm    <= '0;
            cfg_reg.deadband    <= '0;
            cfg_reg.kp          <= '0;
            cfg_reg.ki          <= '0;
            cfg_reg.dir_mask    <= fwpi_pkg::DIR_MASK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fwpi_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_load (out_load),
        .ctl      (ctl)
    );

    fwpi_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .cfg      (cfg_reg),
        .in_data  (s_tdata),
        .in_clear (s_tuser[0]),
        .efforts  (efforts)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= efforts;
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the four-wheel PI speed controller.
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_WHEELS = fwpi_pkg::NUM_WHEELS;
    localparam int CNT_W      = fwpi_pkg::CNT_W;
    localparam int TGT_W      = fwpi_pkg::TGT_W;
    localparam int EFF_W      = fwpi_pkg::EFF_W;
    localparam int GAIN_W     = fwpi_pkg::GAIN_W;
    localparam int ZERO_W     = fwpi_pkg::ZERO_W;
    localparam int DB_W       = fwpi_pkg::DB_W;
    localparam int FRAC_W     = fwpi_pkg::FRAC_W;
    localparam int CFG_ADDR_W = fwpi_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = fwpi_pkg::CFG_DATA_W;
    localparam int S_DATA_W   = fwpi_pkg::S_DATA_W;
    localparam int M_DATA_W   = fwpi_pkg::M_DATA_W;

    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     SETTLE      = 40;
    localparam int     MAX_REPORTS = 100;
    localparam int     PHASES      = 12;
    localparam int     PHASE_TICKS = 125;
    localparam longint S32_MAX     = 64'sd2147483647;
    localparam longint S32_MIN     = -S32_MAX - 1;
    localparam longint S16_MAX     = 64'sd32767;
    localparam longint S16_MIN     = -S16_MAX - 1;

    localparam logic [TGT_W-1:0]      TGT_MAX  = 24'h7F_FFFF;
    localparam logic [TGT_W-1:0]      TGT_MIN  = 24'h80_0000;
    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

    typedef enum int {GAINS_TYPICAL, GAINS_FULL, GAINS_ZERO, GAINS_RANDOM} gain_set_t;

    typedef struct packed {
        logic                              clr;
        logic [NUM_WHEELS-1:0][TGT_W-1:0]  tgt;
        logic [NUM_WHEELS-1:0][CNT_W-1:0]  cnt;
    } tick_t;

    typedef logic [NUM_WHEELS-1:0][EFF_W-1:0] efforts_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    four_wheel_pi_speed_control dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // controller shadow: registers, stored counts and error sums
    fwpi_pkg::cfg_t                   gains;
    logic [CNT_W-1:0]                 prev_count [NUM_WHEELS];
    longint                           err_sum    [NUM_WHEELS];

    tick_t                            pending_ticks [$];
    efforts_t                         expected_efforts [$];
    tick_t                            offered;
    logic [NUM_WHEELS-1:0][CNT_W-1:0] gen_count = '0;
    string                            wheel_name [NUM_WHEELS] = '{"fr", "fl", "bl", "br"};

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_settings = 0;

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // one control tick: update counts and sums, return the four efforts
    function automatic efforts_t wheel_efforts(input tick_t t);
        efforts_t         r;
        logic [CNT_W-1:0] step;
        longint           tgt, spd, err, scaled, base, mapped, acc, eff;
        for (int w = 0; w < NUM_WHEELS; w++) begin
            step = t.cnt[w] - prev_count[w];
            prev_count[w] = t.cnt[w];
            tgt = longint'(signed'(t.tgt[w]));
            spd = clamp_to(longint'(signed'(step)) * longint'(gains.speed_scale),
                           S32_MIN, S32_MAX);
            err = clamp_to(tgt - spd, S32_MIN, S32_MAX);
            if (t.clr) begin
                err_sum[w] = 0;
            end
            err_sum[w] = clamp_to(err_sum[w] + err, S32_MIN, S32_MAX);
            scaled = (err * longint'(gains.pwm_gain)) >>> FRAC_W;
            if (gains.dir_mask[w]) begin
                base   = (longint'(gains.idle_pwm) - longint'(gains.deadband)) * 65536;
                mapped = clamp_to(base - scaled, S32_MIN, S32_MAX);
                acc    = longint'(gains.kp) * mapped - longint'(gains.ki) * err_sum[w];
            end else begin
                base   = (longint'(gains.idle_pwm) + longint'(gains.deadband)) * 65536;
                mapped = clamp_to(base + scaled, S32_MIN, S32_MAX);
                acc    = longint'(gains.kp) * mapped + longint'(gains.ki) * err_sum[w];
            end
            eff = clamp_to(acc >>> 32, S16_MIN, S16_MAX);
            if (tgt == 0) begin
                eff = longint'(gains.idle_pwm);
            end
            r[w] = eff[EFF_W-1:0];
        end
        return r;
    endfunction

    // tick source: hold the offered tick until the transfer, then pull the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_efforts.push_back(wheel_efforts(offered));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    offered = pending_ticks.pop_front();
                    s_tdata  <= {offered.tgt, offered.cnt};
                    s_tuser  <= offered.clr;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // effort sink: compare each transfer against the oldest prediction
    always @(posedge aclk) begin : effort_sink
        efforts_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_efforts.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("%0t  efforts with no tick pending: expected none, got %h",
                                 $time, m_tdata);
                    end
                end else begin
                    want = expected_efforts.pop_front();
                    for (int w = 0; w < NUM_WHEELS; w++) begin
                        if (m_tdata[w*EFF_W +: EFF_W] !== want[w]) begin
                            n_errors++;
                            if (n_errors <= MAX_REPORTS) begin
                                $display("%0t  effort_%s expected %0d got %0d", $time,
                                         wheel_name[w], $signed(want[w]),
                                         $signed(m_tdata[w*EFF_W +: EFF_W]));
                            end
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic queue_tick(input tick_t t);
        pending_ticks.push_back(t);
        gen_count = t.cnt;
        n_queued++;
    endtask

    // mostly smooth encoder motion with random targets; some raw noise
    function automatic tick_t random_tick();
        tick_t t;
        int    lim;
        int    d;
        int    v;
        if ($urandom_range(99) < 15) begin
            for (int w = 0; w < NUM_WHEELS; w++) begin
                t.cnt[w] = $urandom();
                v = $urandom();
                t.tgt[w] = v[TGT_W-1:0];
            end
            t.clr = 1'($urandom_range(1));
            return t;
        end
        for (int w = 0; w < NUM_WHEELS; w++) begin
            case ($urandom_range(3))
                0: lim = 8;
                1: lim = 2000;
                2: lim = 100000;
                default: lim = 0;
            endcase
            if (lim == 0) begin
                d = $urandom();
            end else begin
                d = int'($urandom_range(0, 2 * lim)) - lim;
            end
            t.cnt[w] = gen_count[w] + d;
            case ($urandom_range(9))
                0: t.tgt[w] = '0;
                1: t.tgt[w] = $urandom_range(1) ? TGT_MAX : TGT_MIN;
                default: begin
                    lim = 1 << $urandom_range(4, 22);
                    v = int'($urandom_range(0, 2 * lim)) - lim;
                    t.tgt[w] = v[TGT_W-1:0];
                end
            endcase
        end
        t.clr = ($urandom_range(49) == 0);
        return t;
    endfunction

    task automatic wait_results();
        do @(posedge aclk); while (n_results < n_queued);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        unique case (idx)
            fwpi_pkg::REG_SPEED_SCALE: gains.speed_scale = data[GAIN_W-1:0];
            fwpi_pkg::REG_PWM_GAIN:    gains.pwm_gain    = data[GAIN_W-1:0];
            fwpi_pkg::REG_IDLE_PWM:    gains.idle_pwm    = data[ZERO_W-1:0];
            fwpi_pkg::REG_DEADBAND:    gains.deadband    = data[DB_W-1:0];
            fwpi_pkg::REG_KP:          gains.kp          = data[GAIN_W-1:0];
            fwpi_pkg::REG_KI:          gains.ki          = data[GAIN_W-1:0];
            fwpi_pkg::REG_DIR_MASK:    gains.dir_mask    = data[NUM_WHEELS-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_gains(input gain_set_t kind);
        logic [GAIN_W-1:0]     scale, pgain, kpv, kiv;
        logic [ZERO_W-1:0]     zero;
        logic [DB_W-1:0]       db;
        logic [NUM_WHEELS-1:0] dir;
        logic [CFG_DATA_W-1:0] junk;
        int                    v;
        case (kind)
            GAINS_TYPICAL: begin
                scale = GAIN_W'($urandom_range(0, 'h03_0000));
                pgain = GAIN_W'($urandom_range(0, 'h10_0000));
                v     = int'($urandom_range(0, 2000)) - 1000;
                zero  = v[ZERO_W-1:0];
                db    = DB_W'($urandom_range(0, 300));
                kpv   = GAIN_W'($urandom_range(0, 'h02_0000));
                kiv   = GAIN_W'($urandom_range(0, 'h00_4000));
                dir   = NUM_WHEELS'($urandom_range(15));
            end
            GAINS_FULL: begin
                scale = '1; pgain = '1; zero = 16'h7FFF; db = '1;
                kpv = '1; kiv = '1; dir = '1;
            end
            GAINS_ZERO: begin
                scale = '0; pgain = '0; zero = 16'h8000; db = '0;
                kpv = '0; kiv = '0; dir = '0;
            end
            default: begin
                scale = GAIN_W'($urandom()); pgain = GAIN_W'($urandom());
                zero = ZERO_W'($urandom()); db = DB_W'($urandom());
                kpv = GAIN_W'($urandom()); kiv = GAIN_W'($urandom());
                dir = NUM_WHEELS'($urandom());
            end
        endcase
        // junk above a narrow register's width must be dropped
        junk = CFG_DATA_W'($urandom());
        write_reg(fwpi_pkg::REG_SPEED_SCALE, scale);
        write_reg(fwpi_pkg::REG_PWM_GAIN, pgain);
        write_reg(fwpi_pkg::REG_IDLE_PWM, {junk[CFG_DATA_W-1:ZERO_W], zero});
        write_reg(fwpi_pkg::REG_DEADBAND, {junk[CFG_DATA_W-1:DB_W], db});
        write_reg(fwpi_pkg::REG_KP, kpv);
        write_reg(fwpi_pkg::REG_KI, kiv);
        write_reg(fwpi_pkg::REG_DIR_MASK, {junk[CFG_DATA_W-1:NUM_WHEELS], dir});
        write_reg(REG_NONE, CFG_DATA_W'($urandom()));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic run_directed();
        tick_t t;
        t = '0;
        queue_tick(t);
        t.cnt = {NUM_WHEELS{32'd100}};         t.tgt = {NUM_WHEELS{24'h01_0000}}; queue_tick(t);
        t.cnt = {NUM_WHEELS{32'h7FFF_FFFF}};   t.tgt = {NUM_WHEELS{TGT_MAX}};     queue_tick(t);
        // one step past the positive limit reads as +1
        t.cnt = {NUM_WHEELS{32'h8000_0000}};   t.tgt = {NUM_WHEELS{TGT_MIN}};     queue_tick(t);
        // a half-range jump, zero target on the front right wheel only
        t.cnt = '0; t.tgt = {24'h00_0001, TGT_MIN, TGT_MAX, 24'h00_0000};         queue_tick(t);
        t.clr = 1'b1; t.cnt = {NUM_WHEELS{32'hFFFF_FFF0}};
        t.tgt = {NUM_WHEELS{24'hFF_FFFF}};                                        queue_tick(t);
        // roll across zero
        t.clr = 1'b0; t.cnt = {NUM_WHEELS{32'h0000_0010}};
        t.tgt = {NUM_WHEELS{24'h00_0001}};                                        queue_tick(t);
        t.cnt = {32'd5000, 32'hFFFF_EC78, 32'd0, 32'd16};
        t.tgt = {24'h00_0000, 24'h02_0000, 24'hFE_0000, 24'h00_0000};             queue_tick(t);
        t.clr = 1'b1; t.tgt = {NUM_WHEELS{TGT_MAX}};                              queue_tick(t);
        // drive the sums into saturation in both directions
        t.clr = 1'b0; t.cnt = {NUM_WHEELS{32'hC000_0000}};                        queue_tick(t);
        t.cnt = {NUM_WHEELS{32'h8000_0000}};                                      queue_tick(t);
        t.cnt = {NUM_WHEELS{32'h0000_0000}};   t.tgt = {NUM_WHEELS{TGT_MIN}};     queue_tick(t);
    endtask

    task automatic run_random(input int count, input bit drain_chunks);
        int left;
        int chunk;
        left = count;
        while (left > 0) begin
            chunk = int'($urandom_range(1, 40));
            if (chunk > left) begin
                chunk = left;
            end
            repeat (chunk) queue_tick(random_tick());
            left -= chunk;
            do @(posedge aclk); while (pending_ticks.size() != 0);
            // hold the next chunk until every effort is back
            if (drain_chunks) begin
                wait_results();
            end
        end
    endtask

    initial begin
        gains = '0;
        gains.dir_mask = fwpi_pkg::DIR_MASK_RST;
        for (int w = 0; w < NUM_WHEELS; w++) begin
            prev_count[w] = '0;
            err_sum[w] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_random(20, 1'b0);
        for (int p = 0; p < PHASES; p++) begin
            wait_results();
            repeat (SETTLE) @(posedge aclk);
            apply_gains(gain_set_t'((p / 4 + p) % 4));
            case (p % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 63; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 63; end
                default: begin snd_idle_pct = 20; rcv_stall_pct = 20; end
            endcase
            if (p < 2) begin
                run_directed();
            end
            run_random(PHASE_TICKS, p % 4 == 0);
        end
        wait_results();
        repeat (SETTLE) @(posedge aclk);
        if (expected_efforts.size() != 0) begin
            $display("%0t  %0d effort sets never arrived", $time, expected_efforts.size());
        end
        $display("%0d ticks sent, %0d effort sets checked over %0d register settings",
                 n_accepted, n_results, n_settings);
        $display("idle patterns: none, sender 63%%, receiver 63%%, both 20%%; %0d mismatches",
                 n_errors);
        if (n_errors == 0 && expected_efforts.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("%0t  timeout: %0d ticks queued, %0d effort sets seen", $time,
                 n_queued, n_results);
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fwpi_pkg.sv
rtl/fwpi_mul.sv
rtl/fwpi_seq.sv
rtl/fwpi_dp.sv
rtl/four_wheel_pi_speed_control.sv
dv/tb_top.sv
